/* sv/position_to_pwm_drive_macros.svh */
// ----------------------------------------------------------------------------
// position_to_pwm_drive assertion macros
// Shared property forms for the position drive block; each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef POSITION_TO_PWM_DRIVE_MACROS_SVH
`define POSITION_TO_PWM_DRIVE_MACROS_SVH

// Same-cycle implication, masked while in reset
`define PTPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset
`define PTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ptpd_pkg.sv */
// ----------------------------------------------------------------------------
// ptpd_pkg
// Types and constants shared by the position drive modules.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int POS_W   = 16;
  localparam int POWER_W = 11;
  localparam int CMP_W   = 16;
  localparam int PCT_W   = 7;
  localparam int BITS_W  = 5;
  localparam int IDX_W   = 2;

  // Clamp limit on positions (plus or minus)
  localparam logic signed [POS_W:0] POS_LIMIT = 17'sd32767;

  // Widest PWM resolution in bits
  localparam logic [BITS_W-1:0] PWM_BITS_MAX = 5'd16;

  // mag/40 = (mag >> 3) / 5, done as (x * RECIP5) >> RECIP5_SHIFT
  localparam logic [13:0] RECIP5       = 14'd13108;
  localparam int          RECIP5_SHIFT = 16;

  // y / 25 as (y * RECIP25) >> RECIP25_SHIFT, exact for y below 2^21
  localparam logic [21:0] RECIP25       = 22'd2684355;
  localparam int          RECIP25_SHIFT = 26;

  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  typedef enum logic {
    FUNC_SET_TARGET = 1'b0,
    FUNC_SAMPLE     = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    DRIVE_FWD   = 2'd0,
    DRIVE_REV   = 2'd1,
    DRIVE_BRAKE = 2'd2
  } drive_mode_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MIN_POWER = 2'd0,
    CFG_MAX_POWER = 2'd1,
    CFG_PWM_BITS  = 2'd2
  } cfg_index_t;

  // How the compare value is formed in the last stage
  typedef enum logic [1:0] {
    CMP_FULL_SCALE = 2'd0,
    CMP_ZERO       = 2'd1,
    CMP_PROP       = 2'd2
  } cmp_kind_t;

  // Middle pipeline stage contents
  typedef struct packed {
    drive_mode_t        mode;
    logic [POWER_W-1:0] power;
    logic               off;
    cmp_kind_t          kind;
    logic [PCT_W-1:0]   headroom;
  } mid_t;

endpackage

/* sv/ptpd_power.sv */
// ----------------------------------------------------------------------------
// ptpd_power
// Input register, target store, distance and power level; loads the middle
// stage with direction, power and the compare selection.
// ----------------------------------------------------------------------------
module ptpd_power (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [ptpd_pkg::POS_W-1:0]  in_position_value,
  input  logic [ptpd_pkg::PCT_W-1:0]  min_power,
  input  logic [ptpd_pkg::PCT_W-1:0]  max_power,
  output logic                        mid_valid,
  input  logic                        mid_ready,
  output ptpd_pkg::mid_t              mid
);
  import ptpd_pkg::*;

  logic                    v1_r;
  func_t                   func1_r;
  logic [POS_W-1:0]        pos1_r;
  logic signed [POS_W-1:0] target_r;
  logic                    v2_r;
  mid_t                    mid_r;
  mid_t                    mid_nxt;

  logic                    ready2;
  logic                    move1;
  logic                    load2;
  logic signed [POS_W:0]   pos_ext;
  logic signed [POS_W:0]   pos_c;
  logic signed [POS_W:0]   delta;
  logic [POS_W:0]          mag;
  logic [27:0]             pow_prod;
  logic [POWER_W-1:0]      power;

  // Stage hand-off
  assign ready2   = !v2_r || mid_ready;
  assign move1    = v1_r && ((func1_r == FUNC_SET_TARGET) || ready2);
  assign load2    = move1 && (func1_r == FUNC_SAMPLE);
  assign in_ready = !v1_r || move1;

  // Clamp, distance, magnitude and power level
  always_comb begin
    pos_ext = {pos1_r[POS_W-1], pos1_r};
    if (pos_ext > POS_LIMIT) begin
      pos_c = POS_LIMIT;
    end else if (pos_ext < -POS_LIMIT) begin
      pos_c = -POS_LIMIT;
    end else begin
      pos_c = pos_ext;
    end
    delta    = pos_c - {target_r[POS_W-1], target_r};
    mag      = delta[POS_W] ? (POS_W+1)'(-delta) : (POS_W+1)'(delta);
    pow_prod = 28'(mag[POS_W:3]) * 28'(RECIP5);
    power    = pow_prod[RECIP5_SHIFT +: POWER_W];
  end

  // Direction and compare selection; the brake test wins
  always_comb begin
    mid_nxt.power    = power;
    mid_nxt.mode     = (!delta[POS_W] && (delta != '0)) ? DRIVE_FWD : DRIVE_REV;
    mid_nxt.off      = 1'b0;
    mid_nxt.headroom = '0;
    if (power < POWER_W'(min_power)) begin
      mid_nxt.mode = DRIVE_BRAKE;
      mid_nxt.off  = 1'b1;
      mid_nxt.kind = CMP_FULL_SCALE;
    end else if ((power > POWER_W'(max_power)) || (power >= POWER_W'(FULL_PCT))) begin
      mid_nxt.kind = CMP_ZERO;
    end else begin
      mid_nxt.kind     = CMP_PROP;
      mid_nxt.headroom = FULL_PCT - power[PCT_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      target_r <= '0;
    end else begin
      if (in_ready) begin
        v1_r <= in_valid;
      end
      if (load2) begin
        v2_r <= 1'b1;
      end else if (mid_ready) begin
        v2_r <= 1'b0;
      end
      if (move1 && (func1_r == FUNC_SET_TARGET)) begin
        target_r <= pos_c[POS_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func1_r <= func_t'(in_func);
      pos1_r  <= in_position_value;
    end
    if (load2) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = v2_r;
  assign mid       = mid_r;

endmodule

/* sv/ptpd_compare.sv */
// ----------------------------------------------------------------------------
// ptpd_compare
// Forms the inverted PWM compare value and holds the result register.
// ----------------------------------------------------------------------------
`include "position_to_pwm_drive_macros.svh"

module ptpd_compare (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mid_valid,
  output logic                          mid_ready,
  input  ptpd_pkg::mid_t                mid,
  input  logic [ptpd_pkg::BITS_W-1:0]   pwm_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_drive_mode,
  output logic [ptpd_pkg::CMP_W-1:0]    out_pwm_compare,
  output logic [ptpd_pkg::POWER_W-1:0]  out_power_level,
  output logic                          out_motor_off
);
  import ptpd_pkg::*;

  logic                out_valid_r;
  drive_mode_t         mode_r;
  logic [CMP_W-1:0]    cmp_r;
  logic [CMP_W-1:0]    cmp_nxt;
  logic [POWER_W-1:0]  power_r;
  logic                off_r;

  logic [BITS_W-1:0]   bits;
  logic [CMP_W-1:0]    max_pwm;
  logic [22:0]         num;
  logic [42:0]         quot_prod;

  assign mid_ready = !out_valid_r || out_ready;

  // Full scale and headroom * max_pwm / 100 (max_pwm is 2^b - 1)
  always_comb begin
    bits      = (pwm_bits > PWM_BITS_MAX) ? PWM_BITS_MAX : pwm_bits;
    max_pwm   = CMP_W'((17'd1 << bits) - 17'd1);
    num       = (23'(mid.headroom) << bits) - 23'(mid.headroom);
    quot_prod = 43'(num[22:2]) * 43'(RECIP25);
    case (mid.kind)
      CMP_FULL_SCALE: cmp_nxt = max_pwm;
      CMP_PROP:       cmp_nxt = quot_prod[RECIP25_SHIFT +: CMP_W];
      default:        cmp_nxt = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_ready) begin
      out_valid_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      mode_r  <= mid.mode;
      cmp_r   <= cmp_nxt;
      power_r <= mid.power;
      off_r   <= mid.off;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_mode  = mode_r;
  assign out_pwm_compare = cmp_r;
  assign out_power_level = power_r;
  assign out_motor_off   = off_r;

  // Checks
  `PTPD_ASSERT_NOW(a_off_is_brake, out_valid_r, off_r == (mode_r == DRIVE_BRAKE), "motor_off and brake mode disagree")
  `PTPD_ASSERT_NOW(a_high_power_full_on, out_valid_r && !off_r && (power_r >= POWER_W'(FULL_PCT)), cmp_r == '0, "power of a hundred or more not fully on")
  `PTPD_ASSERT_NEXT(a_zero_kind, mid_valid && mid_ready && (mid.kind == CMP_ZERO), out_valid_r && (cmp_r == '0), "fully-on transaction lost its zero compare")
  `PTPD_ASSERT_NEXT(a_mid_taken, mid_valid && mid_ready, out_valid_r, "accepted transaction did not reach the result register")

endmodule

/* sv/position_to_pwm_drive.sv */
// ----------------------------------------------------------------------------
// position_to_pwm_drive
// Proportional position drive for an H-bridge motor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_func 0 stores a clamped target
//   position and gives no result; in_func 1 is a measured position sample
//   and gives one result on the out_ channel.
//   Result: drive mode (forward, reverse, brake), inverted PWM compare
//   (0 is fully on), power level |distance| / 40 and a motor-off flag.
//   Configuration channel (cfg_valid/cfg_ready, always ready): index 0
//   min_power, 1 max_power, 2 pwm_bits; index 3 is ignored. Write only
//   while no transaction is in flight.
//   Stages: three register stages (input, power, result); a sample passes
//   from the input register through the power stage to the result register.
//   Throughput: one transaction per cycle while out_ready holds, set by the
//   three-stage pipeline, one multiplier in each of its two arithmetic stages.
//   Stall: a sample holds in its stage while the next is full; a target
//   write does not; input is taken until all three stages are occupied.
//   Reset (rst_n low, synchronous): pipeline emptied, target position 0,
//   min_power 0, max_power 100, pwm_bits 8.
// ----------------------------------------------------------------------------
module position_to_pwm_drive (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [ptpd_pkg::POS_W-1:0]    in_position_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_drive_mode,
  output logic [ptpd_pkg::CMP_W-1:0]    out_pwm_compare,
  output logic [ptpd_pkg::POWER_W-1:0]  out_power_level,
  output logic                          out_motor_off,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptpd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ptpd_pkg::PCT_W-1:0]    cfg_data
);
  import ptpd_pkg::*;

  logic [PCT_W-1:0]  min_power_r;
  logic [PCT_W-1:0]  max_power_r;
  logic [BITS_W-1:0] pwm_bits_r;
  logic              mid_valid;
  logic              mid_ready;
  mid_t              mid;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_power_r <= '0;
      max_power_r <= FULL_PCT;
      pwm_bits_r  <= 5'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_POWER: min_power_r <= cfg_data;
        CFG_MAX_POWER: max_power_r <= cfg_data;
        CFG_PWM_BITS:  pwm_bits_r  <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front stages: target, distance, power
  ptpd_power u_power (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_position_value (in_position_value),
    .min_power         (min_power_r),
    .max_power         (max_power_r),
    .mid_valid         (mid_valid),
    .mid_ready         (mid_ready),
    .mid               (mid)
  );

  // Back stage: compare value and result register
  ptpd_compare u_compare (
    .clk             (clk),
    .rst_n           (rst_n),
    .mid_valid       (mid_valid),
    .mid_ready       (mid_ready),
    .mid             (mid),
    .pwm_bits        (pwm_bits_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_mode  (out_drive_mode),
    .out_pwm_compare (out_pwm_compare),
    .out_power_level (out_power_level),
    .out_motor_off   (out_motor_off)
  );

endmodule

/* dv/position_to_pwm_drive_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_to_pwm_drive_checker
// Watches the sample, result and register channels of the position drive,
// predicts each drive result from its own copy of target and settings, and
// compares every result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module position_to_pwm_drive_checker
  import ptpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic [POS_W-1:0]   in_position_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_drive_mode,
  input  logic [CMP_W-1:0]   out_pwm_compare,
  input  logic [POWER_W-1:0] out_power_level,
  input  logic               out_motor_off,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [PCT_W-1:0]   cfg_data,
  output int                 mismatch_count,
  output int                 outstanding
);

  localparam int COUNTS_PER_STEP = 40;  // distance counts per power step
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    drive_mode_t        mode;
    logic [CMP_W-1:0]   compare;
    logic [POWER_W-1:0] power;
    logic               off;
  } drive_t;

  drive_t             pending_drives[$];
  logic [PCT_W-1:0]   brake_below;
  logic [PCT_W-1:0]   full_above;
  logic [BITS_W-1:0]  pwm_res;
  int                 target_angle;
  int                 faults;

  // Sign-extend and clamp to the position limit
  function automatic int clamp_angle(logic [POS_W-1:0] raw);
    int v;
    v = $signed(raw);
    if (v > int'(POS_LIMIT))
      v = int'(POS_LIMIT);
    else if (v < -int'(POS_LIMIT))
      v = -int'(POS_LIMIT);
    return v;
  endfunction

  // Expected drive for a clamped measured angle against the current target
  function automatic drive_t predict_drive(int angle);
    drive_t d;
    int     delta;
    int     mag;
    int     power;
    int     res;
    int     span;
    delta = angle - target_angle;
    mag   = (delta < 0) ? -delta : delta;
    power = mag / COUNTS_PER_STEP;
    res   = (pwm_res > PWM_BITS_MAX) ? int'(PWM_BITS_MAX) : int'(pwm_res);
    span  = (1 << res) - 1;
    d.mode  = (delta > 0) ? DRIVE_FWD : DRIVE_REV;
    d.power = power[POWER_W-1:0];
    d.off   = 1'b0;
    if (power < int'(brake_below)) begin
      d.mode    = DRIVE_BRAKE;
      d.compare = span[CMP_W-1:0];
      d.off     = 1'b1;
    end else if (power > int'(full_above)) begin
      d.compare = '0;
    end else if (power >= int'(FULL_PCT)) begin
      // only reachable with max_power of one hundred or more
      d.compare = '0;
    end else begin
      span      = ((int'(FULL_PCT) - power) * span) / int'(FULL_PCT);
      d.compare = span[CMP_W-1:0];
    end
    return d;
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      brake_below  = '0;
      full_above   = FULL_PCT;
      pwm_res      = 5'd8;
      target_angle = 0;
      faults       = 0;
      pending_drives.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_MIN_POWER: brake_below = cfg_data;
          CFG_MAX_POWER: full_above  = cfg_data;
          CFG_PWM_BITS:  pwm_res     = cfg_data[BITS_W-1:0];
          default: ;
        endcase
      end
      // accepted input transaction
      if (in_valid && in_ready) begin
        if (in_func == FUNC_SET_TARGET)
          target_angle = clamp_angle(in_position_value);
        else
          pending_drives.push_back(predict_drive(clamp_angle(in_position_value)));
      end
      // accepted result transaction
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%0t: drive result with none outstanding: mode %0d compare %0d power %0d off %0d",
                     $time, out_drive_mode, out_pwm_compare, out_power_level, out_motor_off);
        end else begin
          want = pending_drives.pop_front();
          if (out_drive_mode !== want.mode || out_pwm_compare !== want.compare ||
              out_power_level !== want.power || out_motor_off !== want.off) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("%0t: drive mismatch: expected mode %0d compare %0d power %0d off %0d, got mode %0d compare %0d power %0d off %0d",
                       $time, want.mode, want.compare, want.power, want.off,
                       out_drive_mode, out_pwm_compare, out_power_level, out_motor_off);
          end
        end
      end
    end
    mismatch_count <= faults;
    outstanding    <= pending_drives.size();
  end

endmodule

/* dv/position_to_pwm_drive_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_to_pwm_drive_tb
// Drives target and sample transactions into the position drive under a
// series of register settings and handshake idling profiles; the checker
// beside the block predicts and compares every drive result.
// ----------------------------------------------------------------------------
module position_to_pwm_drive_tb;
  import ptpd_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // not a register
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int SETTLE_CYCLES   = 6;     // pipeline depth plus margin
  localparam int NEAR_SPAN       = 5300;  // roughly 130 power steps

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_ready;
  logic               in_func           = 1'b0;
  logic [POS_W-1:0]   in_position_value = '0;
  logic               out_valid;
  logic               out_ready         = 1'b0;
  logic [1:0]         out_drive_mode;
  logic [CMP_W-1:0]   out_pwm_compare;
  logic [POWER_W-1:0] out_power_level;
  logic               out_motor_off;
  logic               cfg_valid         = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index         = '0;
  logic [PCT_W-1:0]   cfg_data          = '0;

  int mismatch_count;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int aim           = 0;  // last target sent, unclamped

  position_to_pwm_drive i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_position_value (in_position_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_mode    (out_drive_mode),
    .out_pwm_compare   (out_pwm_compare),
    .out_power_level   (out_power_level),
    .out_motor_off     (out_motor_off),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  position_to_pwm_drive_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_position_value (in_position_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_mode    (out_drive_mode),
    .out_pwm_compare   (out_pwm_compare),
    .out_power_level   (out_power_level),
    .out_motor_off     (out_motor_off),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  always #5 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One input transaction, with a random gap in front of it
  task automatic send_item(func_t f, logic [POS_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= f;
    in_position_value <= value;
    if (f == FUNC_SET_TARGET)
      aim = int'($signed(value));
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every outstanding drive result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [PCT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sample close to the current target, saturated to the 16-bit range
  function automatic logic [POS_W-1:0] near_aim();
    int v;
    v = aim + int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN;
    if (v > 32767)
      v = 32767;
    else if (v < -32768)
      v = -32768;
    return v[POS_W-1:0];
  endfunction

  task automatic random_items(int count);
    int r;
    logic [POS_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        // new target: mostly random, sometimes at the clamp edges
        case ($urandom_range(5))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h8001;
          default: v = POS_W'($urandom());
        endcase
        send_item(FUNC_SET_TARGET, v);
      end else if (r < 75) begin
        send_item(FUNC_SAMPLE, near_aim());
      end else begin
        v = POS_W'($urandom());
        send_item(FUNC_SAMPLE, v);
      end
    end
  endtask

  // Register settings and idling profile for each random phase
  task automatic set_phase(int p);
    logic [PCT_W-1:0] lo, hi, res;
    case (p)
      0:       begin lo = 7'd10;  hi = 7'd60;  res = 7'h6C; end  // 12 after masking
      1:       begin lo = 7'd0;   hi = 7'd127; res = 7'd16; end
      2:       begin lo = 7'd127; hi = 7'd0;   res = 7'd1;  end
      3:       begin lo = 7'd50;  hi = 7'd20;  res = 7'h7F; end  // 31 after masking
      4:       begin lo = 7'd5;   hi = 7'd100; res = 7'd0;  end
      5:       begin lo = 7'd0;   hi = 7'd0;   res = 7'd20; end
      6:       begin lo = 7'd100; hi = 7'd100; res = 7'd16; end
      default: begin
        lo  = PCT_W'($urandom());
        hi  = PCT_W'($urandom());
        res = PCT_W'($urandom());
      end
    endcase
    write_reg(CFG_MIN_POWER, lo);
    write_reg(CFG_MAX_POWER, hi);
    write_reg(CFG_PWM_BITS, res);
    cfg_valid <= 1'b0;
    case (p % 4)
      0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
      1:       begin send_idle_pct = 51; stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  stall_pct <= 51; end
      default: begin send_idle_pct = 23; stall_pct <= 23; end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default settings, distance extremes and clamp edges
    send_item(FUNC_SAMPLE, 16'd0);
    send_item(FUNC_SAMPLE, 16'd39);
    send_item(FUNC_SAMPLE, 16'd40);
    send_item(FUNC_SAMPLE, -16'sd40);
    send_item(FUNC_SAMPLE, 16'd2000);
    send_item(FUNC_SAMPLE, 16'd4000);
    send_item(FUNC_SAMPLE, 16'd4040);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_SAMPLE, 16'hFFFF);
    send_item(FUNC_SET_TARGET, 16'h8000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_SET_TARGET, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SET_TARGET, 16'h5555);
    send_item(FUNC_SAMPLE, 16'hAAAA);
    drain();

    // write to the unused index must leave the settings alone
    write_reg(CFG_SPARE_IDX, 7'h7F);
    cfg_valid <= 1'b0;
    send_item(FUNC_SET_TARGET, 16'd0);
    send_item(FUNC_SAMPLE, 16'd400);
    send_item(FUNC_SAMPLE, 16'd4080);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      set_phase(p);
      random_items(ITEMS_PER_PHASE);
    end
    drain();

    if (mismatch_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
